@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/core/ppf_pkg.sv @@
package ppf_pkg;

    localparam int SegDepth  = 64;
    localparam int SegIdxW   = $clog2(SegDepth);
    localparam int SegCntW   = SegIdxW + 1;
    localparam int ObjDepth  = 16;
    localparam int ObjIdxW   = $clog2(ObjDepth);
    localparam int ObjCntW   = ObjIdxW + 1;
    localparam int MaxCross  = 64;
    localparam int BudgetW   = $clog2(MaxCross) + 1;
    localparam int InDataW   = 200;
    localparam int OutDataW  = 144;
    localparam int CfgAddrW  = 2;
    localparam int CfgDataW  = 32;

    typedef enum logic [1:0] {
        OPC_LOAD = 2'd0,
        OPC_SNAP = 2'd1,
        OPC_TICK = 2'd2,
        OPC_NONE = 2'd3
    } t_opcode;

    localparam logic [CfgAddrW-1:0] REG_END_MODE  = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_SPEED     = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_SEG_TOTAL = 2'd2;
    localparam logic [CfgAddrW-1:0] REG_OBJ_TOTAL = 2'd3;

    localparam logic [1:0] MODE_STOP     = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [30:0]        len;
    } t_seg;

    typedef struct packed {
        t_opcode            opcode;
        logic [5:0]         slot;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [30:0]        len;
        logic [15:0]        elapsed;
    } t_item;

    typedef struct packed {
        logic [ObjIdxW-1:0] obj;
        logic [SegIdxW-1:0] seg;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [30:0]        along;
        logic               last;
    } t_result;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SNAP_BEGIN,
        OP_SNAP_VEC,
        OP_SNAP_DOT,
        OP_SNAP_T,
        OP_SNAP_ERR,
        OP_SNAP_SQ,
        OP_SNAP_CMP,
        OP_SNAP_WR,
        OP_TICK_BEGIN,
        OP_OBJ_BEGIN,
        OP_EVAL,
        OP_ADD_LEN,
        OP_SET_LEN,
        OP_PLACE_X,
        OP_PLACE_Y,
        OP_PLACE_Z,
        OP_PLACE_W,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        t_opcode opcode;
        logic    slot_ok;
        logic    no_objs;
        logic    neg;
        logic    over;
        logic    budget_zero;
        logic    idx_zero;
        logic    idx_last;
        logic    stop;
        logic    k_last;
        logic    scan_last;
        logic    out_free;
        logic    obj_last;
    } t_sts;

endpackage

@@ rtl/core/polyline_path_follower.sv @@
// Polyline path follower.
// Input stream: one command per transfer, kind in s_axis_tuser (load segment,
// snap object, tick). Load writes one track segment; snap places an object on
// the nearest forward segment; tick moves all attached objects and returns one
// result per object on the output stream, m_axis_tlast on the final one.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_addr at once
// (end mode, speed, segment count, object count); write only while idle.
// Timing: a command is taken in the idle cycle and decoded in the next.
// Load writes the segment in the step after decode. Snap time is set by the
// sequential walk through the single-port segment memory and the shared
// multiply steps. Tick handles one object after another, and its time grows
// with each segment end crossed.
// The output register holds a result until its transfer; while it is full the
// next result waits, and commands are taken again once a tick has issued all.
// Reset: configuration returns to stop mode, zero speed, one segment, no
// objects; every object sits at distance zero on segment zero. Segment
// entries hold nothing until loaded.
module polyline_path_follower
    import ppf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // slot_index, point_x, point_y, point_z, dir_x, dir_y, dir_z,
    // seg_length, elapsed_time, zero fill
    input  logic [InDataW-1:0]  s_axis_tdata,
    // operation
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // object_index, segment_index, pos_x, pos_y, pos_z, along_distance, zero fill
    output logic [OutDataW-1:0] m_axis_tdata,
    output logic                m_axis_tlast,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_sts    sts;
    t_item   item;
    t_result res;

    always_comb begin
        item.opcode  = t_opcode'(s_axis_tuser);
        item.slot    = s_axis_tdata[5:0];
        item.px      = s_axis_tdata[37:6];
        item.py      = s_axis_tdata[69:38];
        item.pz      = s_axis_tdata[101:70];
        item.dx      = s_axis_tdata[117:102];
        item.dy      = s_axis_tdata[133:118];
        item.dz      = s_axis_tdata[149:134];
        item.len     = s_axis_tdata[180:150];
        item.elapsed = s_axis_tdata[196:181];
    end

    ppf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_item     (item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_result (res)
    );

    assign m_axis_tdata = {7'b0, res.along, res.pz, res.py, res.px, res.seg, res.obj};
    assign m_axis_tlast = res.last;

endmodule

@@ rtl/core/ppf_ctrl.sv @@
module ppf_ctrl
    import ppf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_SNAP_BEGIN,
        ST_SNAP_WAIT,
        ST_SNAP_VEC,
        ST_SNAP_DOT,
        ST_SNAP_T,
        ST_SNAP_ERR,
        ST_SNAP_SQ,
        ST_SNAP_CMP,
        ST_SNAP_WR,
        ST_TICK_BEGIN,
        ST_OBJ_BEGIN,
        ST_WAIT_EVAL,
        ST_EVAL,
        ST_WAIT_ADD,
        ST_ADD,
        ST_WAIT_SET,
        ST_SET,
        ST_PLACE_X,
        ST_PLACE_Y,
        ST_PLACE_Z,
        ST_PLACE_W,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.accept = i_s_tvalid && (r_state == ST_IDLE);
        case (r_state)
            ST_LOAD:       o_cmd.op = OP_LOAD;
            ST_SNAP_BEGIN: o_cmd.op = OP_SNAP_BEGIN;
            ST_SNAP_VEC:   o_cmd.op = OP_SNAP_VEC;
            ST_SNAP_DOT:   o_cmd.op = OP_SNAP_DOT;
            ST_SNAP_T:     o_cmd.op = OP_SNAP_T;
            ST_SNAP_ERR:   o_cmd.op = OP_SNAP_ERR;
            ST_SNAP_SQ:    o_cmd.op = OP_SNAP_SQ;
            ST_SNAP_CMP:   o_cmd.op = OP_SNAP_CMP;
            ST_SNAP_WR:    o_cmd.op = OP_SNAP_WR;
            ST_TICK_BEGIN: o_cmd.op = OP_TICK_BEGIN;
            ST_OBJ_BEGIN:  o_cmd.op = OP_OBJ_BEGIN;
            ST_EVAL:       o_cmd.op = OP_EVAL;
            ST_ADD:        o_cmd.op = OP_ADD_LEN;
            ST_SET:        o_cmd.op = OP_SET_LEN;
            ST_PLACE_X:    o_cmd.op = OP_PLACE_X;
            ST_PLACE_Y:    o_cmd.op = OP_PLACE_Y;
            ST_PLACE_Z:    o_cmd.op = OP_PLACE_Z;
            ST_PLACE_W:    o_cmd.op = OP_PLACE_W;
            ST_EMIT:       o_cmd.op = i_sts.out_free ? OP_EMIT : OP_NOP;
            default:       o_cmd.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_sts.opcode)
                    OPC_LOAD: n_state = ST_LOAD;
                    OPC_SNAP: n_state = i_sts.slot_ok ? ST_SNAP_BEGIN : ST_IDLE;
                    OPC_TICK: n_state = ST_TICK_BEGIN;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_LOAD:       n_state = ST_IDLE;
            ST_SNAP_BEGIN: n_state = ST_SNAP_WAIT;
            ST_SNAP_WAIT:  n_state = ST_SNAP_VEC;
            ST_SNAP_VEC:   n_state = ST_SNAP_DOT;
            ST_SNAP_DOT: begin
                if (i_sts.k_last) n_state = ST_SNAP_T;
            end
            ST_SNAP_T:     n_state = ST_SNAP_ERR;
            ST_SNAP_ERR: begin
                if (i_sts.k_last) n_state = ST_SNAP_SQ;
            end
            ST_SNAP_SQ: begin
                if (i_sts.k_last) n_state = ST_SNAP_CMP;
            end
            ST_SNAP_CMP:   n_state = i_sts.scan_last ? ST_SNAP_WR : ST_SNAP_WAIT;
            ST_SNAP_WR:    n_state = ST_IDLE;
            ST_TICK_BEGIN: n_state = i_sts.no_objs ? ST_IDLE : ST_OBJ_BEGIN;
            ST_OBJ_BEGIN:  n_state = ST_WAIT_EVAL;
            ST_WAIT_EVAL:  n_state = ST_EVAL;
            ST_EVAL: begin
                if (i_sts.neg && !i_sts.budget_zero) begin
                    // stop mode at segment zero stays on the same entry
                    n_state = (i_sts.idx_zero && i_sts.stop) ? ST_EVAL : ST_WAIT_ADD;
                end else if (i_sts.over && !i_sts.budget_zero) begin
                    n_state = (i_sts.idx_last && i_sts.stop) ? ST_WAIT_SET : ST_WAIT_EVAL;
                end else begin
                    n_state = ST_PLACE_X;
                end
            end
            ST_WAIT_ADD:   n_state = ST_ADD;
            ST_ADD:        n_state = ST_EVAL;
            ST_WAIT_SET:   n_state = ST_SET;
            ST_SET:        n_state = ST_EVAL;
            ST_PLACE_X:    n_state = ST_PLACE_Y;
            ST_PLACE_Y:    n_state = ST_PLACE_Z;
            ST_PLACE_Z:    n_state = ST_PLACE_W;
            ST_PLACE_W:    n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) n_state = i_sts.obj_last ? ST_IDLE : ST_OBJ_BEGIN;
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/ppf_dp.sv @@
module ppf_dp
    import ppf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  t_item               i_item,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output t_result             o_m_result
);

`include "assert_macros.svh"

    localparam logic [1:0] CompLast = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sd2147483647) res = 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648) res = 32'sh80000000;
        else res = v[31:0];
        return res;
    endfunction

    // configuration
    logic [1:0]         r_mode;
    logic signed [31:0] r_speed;
    logic [6:0]         r_seg_total;
    logic [4:0]         r_obj_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOP;
            r_speed     <= '0;
            r_seg_total <= 7'd1;
            r_obj_total <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_END_MODE:  r_mode      <= i_cfg_data[1:0];
                REG_SPEED:     r_speed     <= i_cfg_data;
                REG_SEG_TOTAL: r_seg_total <= i_cfg_data[6:0];
                REG_OBJ_TOTAL: r_obj_total <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [SegCntW-1:0] seg_n;
    logic [SegIdxW-1:0] n_last;
    logic [SegCntW-1:0] fwd_n;
    logic [ObjCntW-1:0] objs;
    logic               stop;

    always_comb begin
        if (r_seg_total == '0) seg_n = SegCntW'(1);
        else if (SegCntW'(r_seg_total) > SegCntW'(SegDepth)) seg_n = SegCntW'(SegDepth);
        else seg_n = SegCntW'(r_seg_total);
        n_last = SegIdxW'(seg_n - SegCntW'(1));
        fwd_n  = (r_mode == MODE_PINGPONG) ? (seg_n >> 1) : seg_n;
        if (fwd_n == '0) fwd_n = SegCntW'(1);
        objs = (ObjCntW'(r_obj_total) > ObjCntW'(ObjDepth)) ? ObjCntW'(ObjDepth)
                                                            : ObjCntW'(r_obj_total);
        stop = (r_mode == MODE_STOP);
    end

    // latched item
    t_item r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_item;
    end

    // segment memory, registered read
    t_seg               r_mem [SegDepth];
    t_seg               r_q;
    logic [SegIdxW-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mem[r_item.slot[SegIdxW-1:0]] <= '{sx: r_item.px, sy: r_item.py, sz: r_item.pz,
                                               dx: r_item.dx, dy: r_item.dy, dz: r_item.dz,
                                               len: r_item.len};
        end
        r_q <= r_mem[r_idx];
    end

    // object state
    logic [SegIdxW-1:0] r_oseg  [ObjDepth];
    logic signed [32:0] r_odist [ObjDepth];
    logic [ObjIdxW-1:0] r_i;

    // walk and place registers
    logic signed [32:0] r_delta;
    logic signed [33:0] r_d;
    logic [BudgetW-1:0] r_budget;
    logic signed [48:0] r_pprod;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;

    // snap registers
    logic [1:0]         r_k;
    logic signed [32:0] r_v [3];
    logic [30:0]        r_e [3];
    logic signed [50:0] r_acc;
    logic signed [35:0] r_t;
    logic [63:0]        r_sum;
    logic [63:0]        r_best;
    logic [SegIdxW-1:0] r_bj;
    logic signed [35:0] r_bt;

    // output register
    logic    r_ovalid;
    t_result r_out;

    logic signed [33:0] len34;
    assign len34 = $signed({3'b000, r_q.len});

    logic signed [15:0] dir_sel;
    logic signed [32:0] v_sel;
    logic [30:0]        e_sel;
    always_comb begin
        case (r_k)
            2'd0:    begin dir_sel = r_q.dx; v_sel = r_v[0]; e_sel = r_e[0]; end
            2'd1:    begin dir_sel = r_q.dy; v_sel = r_v[1]; e_sel = r_e[1]; end
            default: begin dir_sel = r_q.dz; v_sel = r_v[2]; e_sel = r_e[2]; end
        endcase
    end

    // tick travel
    logic signed [48:0] w_dprod;
    assign w_dprod = 49'(signed'({1'b0, r_item.elapsed})) * 49'(r_speed);

    // object start: saturated distance and stored segment
    logic [SegIdxW-1:0] w_oseg;
    logic signed [33:0] w_dsum;
    logic signed [33:0] w_dsat;
    always_comb begin
        w_oseg = r_oseg[r_i];
        w_dsum = 34'(r_odist[r_i]) + 34'(r_delta);
        if (w_dsum[33] != w_dsum[32]) begin
            w_dsat = w_dsum[33] ? -34'sd4294967296 : 34'sd4294967295;
        end else begin
            w_dsat = w_dsum;
        end
    end

    // place
    logic signed [15:0] w_pdir;
    logic signed [31:0] w_pstart;
    logic signed [48:0] w_pmul;
    logic signed [48:0] w_prnd;
    logic signed [31:0] w_pos;
    always_comb begin
        case (i_cmd.op)
            OP_PLACE_X: w_pdir = r_q.dx;
            OP_PLACE_Y: w_pdir = r_q.dy;
            default:    w_pdir = r_q.dz;
        endcase
        case (i_cmd.op)
            OP_PLACE_Y: w_pstart = r_q.sx;
            OP_PLACE_Z: w_pstart = r_q.sy;
            default:    w_pstart = r_q.sz;
        endcase
        w_pmul = 49'(w_pdir) * 49'(r_d);
        w_prnd = r_pprod + 49'sd16384;
        w_pos  = sat32(36'(w_pstart) + 36'($signed(w_prnd[48:15])));
    end

    // snap arithmetic
    logic signed [50:0] w_dot;
    logic signed [50:0] w_tr;
    logic signed [51:0] w_em;
    logic signed [51:0] w_er;
    logic signed [37:0] w_err;
    logic [30:0]        w_eabs;
    logic [61:0]        w_sq;
    logic signed [35:0] w_tabs;
    logic [32:0]        w_tsat;
    always_comb begin
        w_dot = 51'(v_sel) * 51'(dir_sel);
        w_tr  = r_acc + 51'sd16384;
        w_em  = 52'(dir_sel) * 52'(r_t);
        w_er  = w_em + 52'sd16384;
        w_err = 38'(v_sel) - 38'($signed(w_er[51:15]));
        if (w_err > 38'sd2147483647 || w_err < -38'sd2147483647) begin
            w_eabs = 31'h7FFFFFFF;
        end else if (w_err < 0) begin
            w_eabs = 31'(-w_err);
        end else begin
            w_eabs = w_err[30:0];
        end
        w_sq   = 62'(e_sel) * 62'(e_sel);
        w_tabs = (r_bt < 0) ? -r_bt : r_bt;
        w_tsat = (w_tabs[35:32] != '0) ? 33'h0FFFFFFFF : {1'b0, w_tabs[31:0]};
    end

    // status
    logic obj_last;
    assign obj_last = ((ObjCntW'(r_i) + ObjCntW'(1)) == objs);

    always_comb begin
        o_sts.opcode      = r_item.opcode;
        o_sts.slot_ok     = (SegCntW'(r_item.slot) < SegCntW'(ObjDepth));
        o_sts.no_objs     = (objs == '0);
        o_sts.neg         = r_d[33];
        o_sts.over        = (r_d > len34);
        o_sts.budget_zero = (r_budget == '0);
        o_sts.idx_zero    = (r_idx == '0);
        o_sts.idx_last    = (r_idx == n_last);
        o_sts.stop        = stop;
        o_sts.k_last      = (r_k == CompLast);
        o_sts.scan_last   = (SegCntW'(r_idx) == fwd_n - SegCntW'(1));
        o_sts.out_free    = !r_ovalid || i_m_tready;
        o_sts.obj_last    = obj_last;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SNAP_BEGIN: r_idx <= '0;
            OP_SNAP_VEC: begin
                r_v[0] <= 33'(r_item.px) - 33'(r_q.sx);
                r_v[1] <= 33'(r_item.py) - 33'(r_q.sy);
                r_v[2] <= 33'(r_item.pz) - 33'(r_q.sz);
                r_acc  <= '0;
                r_sum  <= '0;
                r_k    <= '0;
            end
            OP_SNAP_DOT: begin
                r_acc <= r_acc + w_dot;
                r_k   <= (r_k == CompLast) ? 2'd0 : r_k + 2'd1;
            end
            OP_SNAP_T: r_t <= w_tr[50:15];
            OP_SNAP_ERR: begin
                case (r_k)
                    2'd0:    r_e[0] <= w_eabs;
                    2'd1:    r_e[1] <= w_eabs;
                    default: r_e[2] <= w_eabs;
                endcase
                r_k <= (r_k == CompLast) ? 2'd0 : r_k + 2'd1;
            end
            OP_SNAP_SQ: begin
                r_sum <= r_sum + 64'(w_sq);
                r_k   <= (r_k == CompLast) ? 2'd0 : r_k + 2'd1;
            end
            OP_SNAP_CMP: begin
                // lowest error wins, ties keep the earlier segment
                if (r_idx == '0 || r_sum < r_best) begin
                    r_best <= r_sum;
                    r_bj   <= r_idx;
                    r_bt   <= r_t;
                end
                if (!o_sts.scan_last) r_idx <= r_idx + SegIdxW'(1);
            end
            OP_TICK_BEGIN: r_delta <= w_dprod[48:16];
            OP_OBJ_BEGIN: begin
                r_idx    <= (SegCntW'(w_oseg) >= seg_n) ? n_last : w_oseg;
                r_d      <= w_dsat;
                r_budget <= BudgetW'(MaxCross);
            end
            OP_EVAL: begin
                if (r_d[33] && r_budget != '0) begin
                    r_budget <= r_budget - BudgetW'(1);
                    if (r_idx == '0) begin
                        if (stop) r_d <= '0;
                        else r_idx <= n_last;
                    end else begin
                        r_idx <= r_idx - SegIdxW'(1);
                    end
                end else if (r_d > len34 && r_budget != '0) begin
                    r_budget <= r_budget - BudgetW'(1);
                    r_d      <= r_d - len34;
                    if (r_idx == n_last) r_idx <= stop ? n_last : '0;
                    else r_idx <= r_idx + SegIdxW'(1);
                end else begin
                    // settle inside the current segment
                    if (r_d[33]) r_d <= '0;
                    else if (r_d > len34) r_d <= len34;
                end
            end
            OP_ADD_LEN: r_d <= r_d + len34;
            OP_SET_LEN: r_d <= len34;
            OP_PLACE_X: r_pprod <= w_pmul;
            OP_PLACE_Y: begin
                r_pos_x <= w_pos;
                r_pprod <= w_pmul;
            end
            OP_PLACE_Z: begin
                r_pos_y <= w_pos;
                r_pprod <= w_pmul;
            end
            default: ;
        endcase
    end

    // object table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int o = 0; o < ObjDepth; o++) begin
                r_oseg[o]  <= '0;
                r_odist[o] <= '0;
            end
        end else if (i_cmd.op == OP_SNAP_WR) begin
            r_oseg[r_item.slot[ObjIdxW-1:0]]  <= r_bj;
            r_odist[r_item.slot[ObjIdxW-1:0]] <= $signed(w_tsat);
        end else if (i_cmd.op == OP_PLACE_X) begin
            r_oseg[r_i]  <= r_idx;
            r_odist[r_i] <= r_d[32:0];
        end
    end

    // object counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_TICK_BEGIN) r_i <= '0;
        else if (i_cmd.op == OP_EMIT) r_i <= r_i + ObjIdxW'(1);
    end

    // result register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out.obj   <= r_i;
            r_out.seg   <= r_idx;
            r_out.px    <= r_pos_x;
            r_out.py    <= r_pos_y;
            r_out.pz    <= w_pos;
            r_out.along <= (r_d > 34'sd2147483647) ? 31'h7FFFFFFF : r_d[30:0];
            r_out.last  <= obj_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_result = r_out;

    `ASSERT_NEVER(a_emit_full, i_clk, i_rst_n, i_cmd.op == OP_EMIT && r_ovalid && !i_m_tready, "result register overwritten")
    `ASSERT_CLK(a_walk_idx, i_clk, i_rst_n, i_cmd.op == OP_EVAL |-> r_idx <= n_last, "walk index past segment count")
    `ASSERT_CLK(a_settled, i_clk, i_rst_n, i_cmd.op == OP_PLACE_X |-> !r_d[33] && r_d <= len34, "distance outside segment at place")
    `ASSERT_CLK(a_obj_range, i_clk, i_rst_n, i_cmd.op == OP_EMIT |-> (ObjCntW'(r_i) < objs), "object index past object count")

endmodule
